// File: src/eul2rm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eul2rm_pkg
// Shared widths, constants and helper functions of the Euler angle to
// rotation matrix datapath.
// ----------------------------------------------------------------------------
package eul2rm_pkg;

	// field widths
	localparam int ANG_W    = 32;
	localparam int OUT_FRAC = 16;
	localparam int OUT_W    = OUT_FRAC + 2;

	// pipeline depth
	localparam int NST = 36;

	// q30 constants
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [29:0] Q30_HALF = 30'h2000_0000;

	// angle wrap: a multiple of 360 degrees that lifts any input above zero
	localparam logic [32:0] WRAP_OFFS  = 33'd2170552320;
	// floor(v / 45) = (v * MOD45_RCP) >> 20 for v below 2^14
	localparam logic [14:0] MOD45_RCP  = 15'd23302;
	localparam logic [7:0]  DEG45      = 8'd45;
	// pi in q32 is 45 * PI_DIV45 + 15
	localparam logic [28:0] PI_DIV45   = 29'd299845282;
	// floor(v / 3) = (v * DIV3_RCP) >> 25 for v below 2^25
	localparam logic [23:0] DIV3_RCP   = 24'd11184811;
	localparam logic [19:0] RAD_HALF   = 20'h8_0000;

	// series steps and their reciprocals, floor(2^40 / k) + 1
	localparam int NUM_STEPS = 7;
	localparam logic [63:0] P40 = 64'd1 << 40;
	localparam logic [39:0] SER_RCP [2][NUM_STEPS] = '{
		'{40'(P40 / 64'd210 + 64'd1), 40'(P40 / 64'd156 + 64'd1),
		  40'(P40 / 64'd110 + 64'd1), 40'(P40 / 64'd72 + 64'd1),
		  40'(P40 / 64'd42 + 64'd1),  40'(P40 / 64'd20 + 64'd1),
		  40'(P40 / 64'd6 + 64'd1)},
		'{40'(P40 / 64'd182 + 64'd1), 40'(P40 / 64'd132 + 64'd1),
		  40'(P40 / 64'd90 + 64'd1),  40'(P40 / 64'd56 + 64'd1),
		  40'(P40 / 64'd30 + 64'd1),  40'(P40 / 64'd12 + 64'd1),
		  40'(P40 / 64'd2 + 64'd1)}
	};

	// output rounding
	localparam int RND_SH = 30 - OUT_FRAC;
	localparam logic [33:0] RND_HALF = 34'd1 << (RND_SH - 1);
	localparam logic [33:0] OUT_LIM  = 34'd1 << OUT_FRAC;

	// quadrant of the wrapped angle
	typedef enum logic [1:0] {
		QD_0   = 2'd0,
		QD_90  = 2'd1,
		QD_180 = 2'd2,
		QD_270 = 2'd3
	} quad_t;

	// magnitude of a q30 value within +-2
	function automatic logic [30:0] q30_mag(input logic signed [31:0] a);
		return a[31] ? 31'(-a) : a[30:0];
	endfunction

	// round a q60 magnitude to q30, half away from zero, then apply sign
	function automatic logic signed [31:0] q30_rnd(input logic [61:0] p, input logic neg);
		logic [62:0] s;
		logic [31:0] m;
		s = 63'(p) + 63'(Q30_HALF);
		m = 32'(s >> 30);
		return neg ? $signed(-m) : $signed(m);
	endfunction

	// q30 to saturated q1.OUT_FRAC
	function automatic logic [OUT_W-1:0] to_out(input logic signed [32:0] v);
		logic [32:0] m;
		logic [33:0] r;
		logic [OUT_W-1:0] o;
		m = v[32] ? 33'(-v) : 33'(v);
		r = (34'(m) + RND_HALF) >> RND_SH;
		if (r > OUT_LIM) r = OUT_LIM;
		o = OUT_W'(r);
		return v[32] ? OUT_W'(-o) : o;
	endfunction

endpackage
`default_nettype wire

// File: src/eul2rm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eul2rm_in_if
// Angle channel: one pitch, yaw, roll triple per transaction.
// ----------------------------------------------------------------------------
interface eul2rm_in_if;
	logic valid;
	logic ready;
	logic signed [eul2rm_pkg::ANG_W-1:0] pitch_deg;
	logic signed [eul2rm_pkg::ANG_W-1:0] yaw_deg;
	logic signed [eul2rm_pkg::ANG_W-1:0] roll_deg;

	modport source (output valid, pitch_deg, yaw_deg, roll_deg, input ready);
	modport sink (input valid, pitch_deg, yaw_deg, roll_deg, output ready);
endinterface
`default_nettype wire

// File: src/eul2rm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eul2rm_out_if
// Matrix channel: nine q1.16 entries per transaction.
// ----------------------------------------------------------------------------
interface eul2rm_out_if;
	logic valid;
	logic ready;
	logic signed [eul2rm_pkg::OUT_W-1:0] row0_x, row0_y, row0_z;
	logic signed [eul2rm_pkg::OUT_W-1:0] row1_x, row1_y, row1_z;
	logic signed [eul2rm_pkg::OUT_W-1:0] row2_x, row2_y, row2_z;

	modport source (output valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
		row2_x, row2_y, row2_z, input ready);
	modport sink (input valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
		row2_x, row2_y, row2_z, output ready);
endinterface
`default_nettype wire

// File: src/euler_angles_to_rotation_matrix.sv
// Throughput: one transaction per cycle while no output stall reaches the input; each of the 36 stages holds one item.
// The sine and cosine series take 21 of those stages (7 steps of 3 stages).
// A stalled output only holds back the stages behind it that are full.
// Reset (arst_n low) clears the stage valid bits; data registers are not reset.
`default_nettype none
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// Pipelined pitch/yaw/roll to 3x3 rotation matrix: angle wrap, fixed-point
// sine and cosine series per angle, then two rounds of q30 products.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix (
	input  wire logic        clk,
	input  wire logic        arst_n,
	eul2rm_in_if.sink        angles,
	eul2rm_out_if.source     matrix
);

	localparam int NS   = eul2rm_pkg::NUM_STEPS;
	localparam int ST_F2 = 29;

	// stage valid bits and advance enables
	logic [eul2rm_pkg::NST-1:0] vld_q;
	logic [eul2rm_pkg::NST-1:0] adv;

	// stage i may load when some stage at or after it is empty or the sink takes
	always_comb begin
		for (int i = 0; i < eul2rm_pkg::NST; i++) begin
			adv[i] = matrix.ready ||
				((vld_q | ((eul2rm_pkg::NST'(1) << i) - eul2rm_pkg::NST'(1))) != '1);
		end
	end

	assign angles.ready = adv[0];
	assign matrix.valid = vld_q[eul2rm_pkg::NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < eul2rm_pkg::NST; i++) begin
				if (adv[i]) vld_q[i] <= (i == 0) ? angles.valid : vld_q[(i == 0) ? 0 : i - 1];
			end
		end
	end

	// lane inputs: pitch, yaw, roll
	logic signed [31:0] raw_c [3];
	always_comb begin
		raw_c[0] = angles.pitch_deg;
		raw_c[1] = angles.yaw_deg;
		raw_c[2] = angles.roll_deg;
	end

	// front stages: wrap, quadrant split, radians, square
	logic [13:0] v_s1 [3];
	logic [18:0] lo_s1 [3];
	logic [13:0] v_s2 [3];
	logic [18:0] lo_s2 [3];
	logic [7:0]  q_s2 [3];
	logic [22:0] rem_s3 [3];
	eul2rm_pkg::quad_t qd_s3 [3], qd_s4 [3], qd_s5 [3], qd_s6 [3], qd_s7 [3];
	logic [51:0] pa_s4 [3];
	logic [46:0] pb_s4 [3];
	logic [30:0] x_s5 [3], x_s6 [3], x_s7 [3];
	logic [61:0] xx_s6 [3];
	logic [31:0] x2_s7 [3];

	logic [32:0] u_c [3];
	logic [5:0]  r_c [3];
	logic [7:0]  w_c [3];
	logic [7:0]  remw_c [3];
	eul2rm_pkg::quad_t qd_c [3];

	// modulo 45 of the upper angle bits and quadrant compare
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			u_c[l] = 33'(raw_c[l]) + eul2rm_pkg::WRAP_OFFS;
			r_c[l] = 6'(v_s2[l] - 14'(q_s2[l]) * 14'(eul2rm_pkg::DEG45));
			w_c[l] = {r_c[l], lo_s2[l][18:17]};
			if (w_c[l] >= 8'd135) begin
				qd_c[l] = eul2rm_pkg::QD_270;
				remw_c[l] = w_c[l] - 8'd135;
			end else if (w_c[l] >= 8'd90) begin
				qd_c[l] = eul2rm_pkg::QD_180;
				remw_c[l] = w_c[l] - 8'd90;
			end else if (w_c[l] >= eul2rm_pkg::DEG45) begin
				qd_c[l] = eul2rm_pkg::QD_90;
				remw_c[l] = w_c[l] - eul2rm_pkg::DEG45;
			end else begin
				qd_c[l] = eul2rm_pkg::QD_0;
				remw_c[l] = w_c[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (adv[0]) begin
				v_s1[l]  <= u_c[l][32:19];
				lo_s1[l] <= u_c[l][18:0];
			end
			if (adv[1]) begin
				q_s2[l]  <= 8'((29'(v_s1[l]) * 29'(eul2rm_pkg::MOD45_RCP)) >> 20);
				v_s2[l]  <= v_s1[l];
				lo_s2[l] <= lo_s1[l];
			end
			if (adv[2]) begin
				rem_s3[l] <= {remw_c[l][5:0], lo_s2[l][16:0]};
				qd_s3[l]  <= qd_c[l];
			end
			if (adv[3]) begin
				pa_s4[l] <= 52'(rem_s3[l]) * 52'(eul2rm_pkg::PI_DIV45);
				pb_s4[l] <= 47'(rem_s3[l]) * 47'(eul2rm_pkg::DIV3_RCP);
				qd_s4[l] <= qd_s3[l];
			end
			if (adv[4]) begin
				x_s5[l]  <= 31'((pa_s4[l] + 52'(eul2rm_pkg::RAD_HALF) + 52'(pb_s4[l] >> 25)) >> 20);
				qd_s5[l] <= qd_s4[l];
			end
			if (adv[5]) begin
				xx_s6[l] <= 62'(x_s5[l]) * 62'(x_s5[l]);
				x_s6[l]  <= x_s5[l];
				qd_s6[l] <= qd_s5[l];
			end
			if (adv[6]) begin
				x2_s7[l] <= 32'((63'(xx_s6[l]) + 63'(eul2rm_pkg::Q30_HALF)) >> 30);
				x_s7[l]  <= x_s6[l];
				qd_s7[l] <= qd_s6[l];
			end
		end
	end

	// series steps: a = x2*t, b = reciprocal partial products, c = one minus quotient
	logic [31:0] n_sa [3][2][NS];
	logic [31:0] x2_sa [3][NS], x2_sb [3][NS], x2_sc [3][NS];
	logic [30:0] x_sa [3][NS], x_sb [3][NS], x_sc [3][NS];
	eul2rm_pkg::quad_t qd_sa [3][NS], qd_sb [3][NS], qd_sc [3][NS];
	logic [51:0] ph_sb [3][2][NS];
	logic [51:0] pl_sb [3][2][NS];
	logic [30:0] t_sc [3][2][NS];

	logic [31:0] srcx2_c [3][NS];
	logic [30:0] srcx_c [3][NS];
	eul2rm_pkg::quad_t srcqd_c [3][NS];
	logic [30:0] srct_c [3][2][NS];
	logic [72:0] qsum_c [3][2][NS];
	logic [32:0] qv_c [3][2][NS];
	logic [30:0] tnew_c [3][2][NS];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			srcx2_c[l][0] = x2_s7[l];
			srcx_c[l][0]  = x_s7[l];
			srcqd_c[l][0] = qd_s7[l];
			for (int c = 0; c < 2; c++) srct_c[l][c][0] = eul2rm_pkg::Q30_ONE;
			for (int j = 1; j < NS; j++) begin
				srcx2_c[l][j] = x2_sc[l][j-1];
				srcx_c[l][j]  = x_sc[l][j-1];
				srcqd_c[l][j] = qd_sc[l][j-1];
				for (int c = 0; c < 2; c++) srct_c[l][c][j] = t_sc[l][c][j-1];
			end
			for (int c = 0; c < 2; c++) begin
				for (int j = 0; j < NS; j++) begin
					qsum_c[l][c][j] = (73'(ph_sb[l][c][j]) << 20) + 73'(pl_sb[l][c][j]);
					qv_c[l][c][j]   = 33'(qsum_c[l][c][j] >> 40);
					tnew_c[l][c][j] = (qv_c[l][c][j] >= 33'(eul2rm_pkg::Q30_ONE)) ? 31'd0 :
						31'(33'(eul2rm_pkg::Q30_ONE) - qv_c[l][c][j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			for (int j = 0; j < NS; j++) begin
				if (adv[7 + 3 * j]) begin
					x2_sa[l][j] <= srcx2_c[l][j];
					x_sa[l][j]  <= srcx_c[l][j];
					qd_sa[l][j] <= srcqd_c[l][j];
					for (int c = 0; c < 2; c++)
						n_sa[l][c][j] <= 32'((63'(srcx2_c[l][j]) * 63'(srct_c[l][c][j])) >> 30);
				end
				if (adv[8 + 3 * j]) begin
					x2_sb[l][j] <= x2_sa[l][j];
					x_sb[l][j]  <= x_sa[l][j];
					qd_sb[l][j] <= qd_sa[l][j];
					for (int c = 0; c < 2; c++) begin
						ph_sb[l][c][j] <= 52'(n_sa[l][c][j]) * 52'(eul2rm_pkg::SER_RCP[c][j][39:20]);
						pl_sb[l][c][j] <= 52'(n_sa[l][c][j]) * 52'(eul2rm_pkg::SER_RCP[c][j][19:0]);
					end
				end
				if (adv[9 + 3 * j]) begin
					x2_sc[l][j] <= x2_sb[l][j];
					x_sc[l][j]  <= x_sb[l][j];
					qd_sc[l][j] <= qd_sb[l][j];
					for (int c = 0; c < 2; c++) t_sc[l][c][j] <= tnew_c[l][c][j];
				end
			end
		end
	end

	// sine from x times series, then quadrant mirroring
	logic [61:0] sx_s29 [3];
	logic [30:0] cs_s29 [3];
	eul2rm_pkg::quad_t qd_s29 [3];
	logic signed [31:0] sin_s30 [3], cos_s30 [3];

	logic [31:0] s_c [3];
	logic signed [31:0] si_c [3], ci_c [3], sn_c [3], cn_c [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			s_c[l] = 32'((63'(sx_s29[l]) + 63'(eul2rm_pkg::Q30_HALF)) >> 30);
			if (s_c[l] > 32'(eul2rm_pkg::Q30_ONE)) s_c[l] = 32'(eul2rm_pkg::Q30_ONE);
			si_c[l] = $signed(s_c[l]);
			ci_c[l] = $signed(32'(cs_s29[l]));
			case (qd_s29[l])
				eul2rm_pkg::QD_0: begin
					sn_c[l] = si_c[l];
					cn_c[l] = ci_c[l];
				end
				eul2rm_pkg::QD_90: begin
					sn_c[l] = ci_c[l];
					cn_c[l] = -si_c[l];
				end
				eul2rm_pkg::QD_180: begin
					sn_c[l] = -si_c[l];
					cn_c[l] = -ci_c[l];
				end
				default: begin
					sn_c[l] = -ci_c[l];
					cn_c[l] = si_c[l];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (adv[28]) begin
				sx_s29[l] <= 62'(x_sc[l][NS-1]) * 62'(t_sc[l][0][NS-1]);
				cs_s29[l] <= t_sc[l][1][NS-1];
				qd_s29[l] <= qd_sc[l][NS-1];
			end
			if (adv[ST_F2]) begin
				sin_s30[l] <= sn_c[l];
				cos_s30[l] <= cn_c[l];
			end
		end
	end

	// first product round: sr*sp, cr*sp and the single products
	logic signed [31:0] opa_c [10], opb_c [10];
	logic [61:0] prd_s31 [10];
	logic        neg_s31 [10];
	logic signed [31:0] sp_s31, cy_s31, sy_s31;
	logic signed [31:0] val_s32 [10];
	logic signed [31:0] sp_s32, cy_s32, sy_s32;

	always_comb begin
		opa_c[0] = sin_s30[2]; opb_c[0] = sin_s30[0];
		opa_c[1] = cos_s30[2]; opb_c[1] = sin_s30[0];
		opa_c[2] = cos_s30[0]; opb_c[2] = cos_s30[1];
		opa_c[3] = cos_s30[0]; opb_c[3] = sin_s30[1];
		opa_c[4] = sin_s30[2]; opb_c[4] = cos_s30[0];
		opa_c[5] = cos_s30[2]; opb_c[5] = cos_s30[0];
		opa_c[6] = cos_s30[2]; opb_c[6] = sin_s30[1];
		opa_c[7] = cos_s30[2]; opb_c[7] = cos_s30[1];
		opa_c[8] = sin_s30[2]; opb_c[8] = sin_s30[1];
		opa_c[9] = sin_s30[2]; opb_c[9] = cos_s30[1];
	end

	always_ff @(posedge clk) begin
		if (adv[30]) begin
			for (int i = 0; i < 10; i++) begin
				prd_s31[i] <= 62'(eul2rm_pkg::q30_mag(opa_c[i])) *
					62'(eul2rm_pkg::q30_mag(opb_c[i]));
				neg_s31[i] <= opa_c[i][31] ^ opb_c[i][31];
			end
			sp_s31 <= sin_s30[0];
			cy_s31 <= cos_s30[1];
			sy_s31 <= sin_s30[1];
		end
		if (adv[31]) begin
			for (int i = 0; i < 10; i++) val_s32[i] <= eul2rm_pkg::q30_rnd(prd_s31[i], neg_s31[i]);
			sp_s32 <= sp_s31;
			cy_s32 <= cy_s31;
			sy_s32 <= sy_s31;
		end
	end

	// second product round: (sr*sp), (cr*sp) times cy and sy
	logic signed [31:0] opc_c [4], opd_c [4];
	logic [61:0] prd_s33 [4];
	logic        neg_s33 [4];
	logic signed [31:0] val_s33 [10];
	logic signed [31:0] sp_s33;
	logic signed [31:0] w2_s34 [4];
	logic signed [31:0] val_s34 [10];
	logic signed [31:0] sp_s34;

	always_comb begin
		opc_c[0] = val_s32[0]; opd_c[0] = cy_s32;
		opc_c[1] = val_s32[0]; opd_c[1] = sy_s32;
		opc_c[2] = val_s32[1]; opd_c[2] = cy_s32;
		opc_c[3] = val_s32[1]; opd_c[3] = sy_s32;
	end

	always_ff @(posedge clk) begin
		if (adv[32]) begin
			for (int i = 0; i < 4; i++) begin
				prd_s33[i] <= 62'(eul2rm_pkg::q30_mag(opc_c[i])) *
					62'(eul2rm_pkg::q30_mag(opd_c[i]));
				neg_s33[i] <= opc_c[i][31] ^ opd_c[i][31];
			end
			val_s33 <= val_s32;
			sp_s33  <= sp_s32;
		end
		if (adv[33]) begin
			for (int i = 0; i < 4; i++) w2_s34[i] <= eul2rm_pkg::q30_rnd(prd_s33[i], neg_s33[i]);
			val_s34 <= val_s33;
			sp_s34  <= sp_s33;
		end
	end

	// row sums, then rounding and saturation to the output format
	logic signed [32:0] m_s35 [9];
	logic [eul2rm_pkg::OUT_W-1:0] out_s36 [9];

	always_ff @(posedge clk) begin
		if (adv[34]) begin
			m_s35[0] <= 33'(val_s34[2]);
			m_s35[1] <= 33'(val_s34[3]);
			m_s35[2] <= -33'(sp_s34);
			m_s35[3] <= 33'(w2_s34[0]) - 33'(val_s34[6]);
			m_s35[4] <= 33'(w2_s34[1]) + 33'(val_s34[7]);
			m_s35[5] <= 33'(val_s34[4]);
			m_s35[6] <= 33'(w2_s34[2]) + 33'(val_s34[8]);
			m_s35[7] <= 33'(w2_s34[3]) - 33'(val_s34[9]);
			m_s35[8] <= 33'(val_s34[5]);
		end
		if (adv[35]) begin
			for (int i = 0; i < 9; i++) out_s36[i] <= eul2rm_pkg::to_out(m_s35[i]);
		end
	end

	assign matrix.row0_x = out_s36[0];
	assign matrix.row0_y = out_s36[1];
	assign matrix.row0_z = out_s36[2];
	assign matrix.row1_x = out_s36[3];
	assign matrix.row1_y = out_s36[4];
	assign matrix.row1_z = out_s36[5];
	assign matrix.row2_x = out_s36[6];
	assign matrix.row2_y = out_s36[7];
	assign matrix.row2_z = out_s36[8];

`ifndef SYNTHESIS
	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!matrix.valid |-> angles.ready)
		else $error("input blocked with empty output stage");

	// an accepted transaction occupies the first stage next cycle
	a_enter_stage: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid && angles.ready |=> vld_q[0])
		else $error("accepted transaction lost at first stage");

	// mirrored pitch sine and roll cosine stay within one
	a_sincos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_F2] |-> (sin_s30[0] <= 32'sd1073741824 && sin_s30[0] >= -32'sd1073741824 &&
			cos_s30[2] <= 32'sd1073741824 && cos_s30[2] >= -32'sd1073741824))
		else $error("sine or cosine out of range");

	// outputs row1_x and row2_y saturate at plus or minus one
	a_out_sat: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid |-> (matrix.row1_x <= 18'sd65536 && matrix.row1_x >= -18'sd65536 &&
			matrix.row2_y <= 18'sd65536 && matrix.row2_y >= -18'sd65536))
		else $error("matrix entry beyond saturation limit");
`endif

endmodule
`default_nettype wire
